// ===== rtl/abba_pkg.sv =====
// abba_pkg: shared types and constants for the abba-baba d-statistic accumulator
// holds the word layouts of both channels, fixed-point widths and control codes
// no dependencies

package abba_pkg;

  // default sizes of the statistic and bin stores
  localparam int NUM_STATS_DEF = 16;
  localparam int NUM_BINS_DEF  = 128;

  // fraction bits of the allele frequencies, 1.0 == 2**FREQ_BITS
  localparam int FREQ_BITS = 16;
  localparam int FREQ_W    = 17;
  localparam int ONE_W     = FREQ_BITS + 1;
  localparam int MUL_W     = FREQ_BITS + 2;
  localparam int PROD_W    = 2 * MUL_W;
  localparam int RAW_W     = 2 * FREQ_BITS + 1;

  // per-site terms after conversion to 32 fraction bits never exceed 2**32
  localparam int Q_W   = 33;
  localparam int Q_RSH = (2 * FREQ_BITS >= 32) ? 2 * FREQ_BITS - 32 : 0;
  localparam int Q_LSH = (2 * FREQ_BITS >= 32) ? 0 : 32 - 2 * FREQ_BITS;

  localparam logic [ONE_W-1:0] FREQ_ONE = {1'b1, {FREQ_BITS{1'b0}}};

  // item modes
  localparam logic MODE_ACC  = 1'b0;
  localparam logic MODE_READ = 1'b1;

  // multiplier schedule, one product per step
  localparam logic [2:0] STEP_PAB    = 3'd0;
  localparam logic [2:0] STEP_PBA    = 3'd1;
  localparam logic [2:0] STEP_PCD    = 3'd2;
  localparam logic [2:0] STEP_PDC    = 3'd3;
  localparam logic [2:0] STEP_DEN    = 3'd4;
  localparam logic [2:0] STEP_BABA_A = 3'd5;
  localparam logic [2:0] STEP_BABA_B = 3'd6;
  localparam logic [2:0] STEP_NUM    = 3'd7;

  typedef struct packed {
    logic              mode;
    logic [3:0]        stat_index;
    logic [6:0]        bin_index;
    logic              missing;
    logic [FREQ_W-1:0] freq_a;
    logic [FREQ_W-1:0] freq_b;
    logic [FREQ_W-1:0] freq_c;
    logic [FREQ_W-1:0] freq_d;
  } site_t;

  typedef struct packed {
    logic signed [63:0] total_numerator;
    logic [62:0]        total_denominator;
    logic [62:0]        total_abba;
    logic [62:0]        total_baba;
    logic [31:0]        total_sites;
    logic signed [63:0] loo_numerator;
    logic [62:0]        loo_denominator;
    logic [31:0]        loo_sites;
  } result_t;

  // sequencer to product unit
  typedef struct packed {
    logic       load;
    logic       mul;
    logic [2:0] step;
    logic       conv;
  } prod_ctrl_t;

  // per-site terms with 32 fraction bits
  typedef struct packed {
    logic signed [Q_W:0] numerator;
    logic [Q_W-1:0]      denominator;
    logic [Q_W-1:0]      abba;
    logic [Q_W-1:0]      baba;
  } terms_t;

endpackage

// ===== rtl/abba_prod_unit.sv =====
// abba_prod_unit: shared multiplier that forms the per-site terms one product a step
// depends on abba_pkg; stepped by the sequencer in the top level

module abba_prod_unit
  import abba_pkg::*;
(
  input  logic       clk,
  input  site_t      site,
  input  prod_ctrl_t ctrl,
  output terms_t     terms
);

  function automatic logic [ONE_W-1:0] clamp_freq(input logic [FREQ_W-1:0] v);
    logic [31:0] x;
    x = 32'(v);
    if (x > 32'(FREQ_ONE)) x = 32'(FREQ_ONE);
    return x[ONE_W-1:0];
  endfunction

  // bring 2*FREQ_BITS fraction bits to 32 fraction bits
  function automatic logic [Q_W-1:0] to_q32(input logic [RAW_W-1:0] v);
    logic [63:0] w;
    w = 64'(v);
    w = (w >> Q_RSH) << Q_LSH;
    return w[Q_W-1:0];
  endfunction

  logic [ONE_W-1:0]         fa, fb, fc, fd;
  logic [ONE_W-1:0]         pab, pba, pcd, pdc;
  logic [RAW_W-1:0]         den_raw, baba_raw;
  logic signed [RAW_W:0]    num_raw;
  logic signed [MUL_W-1:0]  op_x, op_y;
  logic signed [PROD_W-1:0] prod;
  logic                     num_neg;
  logic [RAW_W-1:0]         num_mag;
  logic signed [Q_W:0]      num_q;

  // operand select for the shared multiplier
  always_comb begin
    op_x = '0;
    op_y = '0;
    case (ctrl.step)
      STEP_PAB: begin
        op_x = $signed(MUL_W'(fa));
        op_y = $signed(MUL_W'(FREQ_ONE - fb));
      end
      STEP_PBA: begin
        op_x = $signed(MUL_W'(FREQ_ONE - fa));
        op_y = $signed(MUL_W'(fb));
      end
      STEP_PCD: begin
        op_x = $signed(MUL_W'(fc));
        op_y = $signed(MUL_W'(FREQ_ONE - fd));
      end
      STEP_PDC: begin
        op_x = $signed(MUL_W'(FREQ_ONE - fc));
        op_y = $signed(MUL_W'(fd));
      end
      STEP_DEN: begin
        op_x = $signed(MUL_W'(pab) + MUL_W'(pba));
        op_y = $signed(MUL_W'(pcd) + MUL_W'(pdc));
      end
      STEP_BABA_A: begin
        op_x = $signed(MUL_W'(pab));
        op_y = $signed(MUL_W'(pcd));
      end
      STEP_BABA_B: begin
        op_x = $signed(MUL_W'(pba));
        op_y = $signed(MUL_W'(pdc));
      end
      STEP_NUM: begin
        op_x = $signed(MUL_W'(fa)) - $signed(MUL_W'(fb));
        op_y = $signed(MUL_W'(fc)) - $signed(MUL_W'(fd));
      end
      default: begin
        op_x = '0;
        op_y = '0;
      end
    endcase
    prod = op_x * op_y;
  end

  // sign and magnitude of the numerator, truncation toward zero
  always_comb begin
    num_neg = num_raw[RAW_W];
    num_mag = num_neg ? RAW_W'(-num_raw) : RAW_W'(num_raw);
    num_q   = $signed({1'b0, to_q32(num_mag)});
  end

  // operand capture, product capture and conversion
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      fa <= clamp_freq(site.freq_a);
      fb <= clamp_freq(site.freq_b);
      fc <= clamp_freq(site.freq_c);
      fd <= clamp_freq(site.freq_d);
    end
    if (ctrl.mul) begin
      case (ctrl.step)
        STEP_PAB:    pab <= prod[FREQ_BITS +: ONE_W];
        STEP_PBA:    pba <= prod[FREQ_BITS +: ONE_W];
        STEP_PCD:    pcd <= prod[FREQ_BITS +: ONE_W];
        STEP_PDC:    pdc <= prod[FREQ_BITS +: ONE_W];
        STEP_DEN:    den_raw <= prod[RAW_W-1:0];
        STEP_BABA_A: baba_raw <= prod[RAW_W-1:0];
        STEP_BABA_B: baba_raw <= baba_raw + prod[RAW_W-1:0];
        STEP_NUM:    num_raw <= prod[RAW_W:0];
        default:     ;
      endcase
    end
    if (ctrl.conv) begin
      terms.numerator   <= num_neg ? -num_q : num_q;
      terms.denominator <= to_q32(den_raw);
      terms.baba        <= to_q32(baba_raw);
      // abba + baba equals the denominator product exactly
      terms.abba        <= to_q32(den_raw - baba_raw);
    end
  end

endmodule

// ===== rtl/abba_baba_dstat_accumulator_top.sv =====
// abba_baba_dstat_accumulator_top: per-statistic and per-bin abba-baba sums
// depends on abba_pkg and abba_prod_unit; checked by abba_port_checker
//
// Usage. Site words come in on site/site_valid/site_stall, result words leave on
// result/result_valid/result_stall; a word moves when valid is high and stall low.
// An accumulate word (mode 0) adds the site's numerator, denominator, abba and
// baba terms and a site count to its statistic, and its numerator, denominator
// and site count to its statistic's bin; it gives no result. A skipped site
// (missing, or index out of range) is taken and dropped. A readout word
// (mode 1) gives one result: the totals of the statistic and the totals minus
// the chosen bin. An accumulate site stalls the input while the single shared
// multiplier forms eight products one after another, then while its terms are
// converted and both stores get one read-modify-write.
// A readout goes through store read, result formed, result register loaded.
// Reset: the block clears both stores, one statistic-bin entry per cycle, all
// NUM_STATS * NUM_BINS entries (2048 by default), with site_stall high.
// A stalled result stays in its output register; the next site word is still
// taken meanwhile, and a readout behind it waits until the register frees up.

module abba_baba_dstat_accumulator_top
  import abba_pkg::*;
#(
  parameter int NUM_STATS = NUM_STATS_DEF,
  parameter int NUM_BINS  = NUM_BINS_DEF
)
(
  input  logic    clk,
  input  logic    rst,
  input  logic    site_valid,
  output logic    site_stall,
  input  site_t   site,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  localparam int DEPTH   = NUM_STATS * NUM_BINS;
  localparam int STAT_AW = (NUM_STATS > 1) ? $clog2(NUM_STATS) : 1;
  localparam int BIN_AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam logic signed [63:0] S64_MAX = {1'b0, {63{1'b1}}};
  localparam logic signed [63:0] S64_MIN = {1'b1, {63{1'b0}}};

  typedef struct packed {
    logic signed [63:0] numerator;
    logic [62:0]        denominator;
    logic [62:0]        abba;
    logic [62:0]        baba;
    logic [31:0]        sites;
  } stat_rec_t;

  typedef struct packed {
    logic signed [63:0] numerator;
    logic [62:0]        denominator;
    logic [31:0]        sites;
  } bin_rec_t;

  typedef enum logic [6:0] {
    ST_CLEAR  = 7'b0000001,
    ST_IDLE   = 7'b0000010,
    ST_MUL    = 7'b0000100,
    ST_CONV   = 7'b0001000,
    ST_UPD    = 7'b0010000,
    ST_RDWAIT = 7'b0100000,
    ST_RDOUT  = 7'b1000000
  } state_t;

  function automatic logic signed [63:0] sat_add_s64(input logic signed [63:0] acc,
                                                     input logic signed [Q_W:0] v);
    logic signed [64:0] s;
    s = 65'(acc) + 65'(v);
    if (s[64] != s[63]) return s[64] ? S64_MIN : S64_MAX;
    return s[63:0];
  endfunction

  function automatic logic signed [63:0] sat_sub_s64(input logic signed [63:0] a,
                                                     input logic signed [63:0] b);
    logic signed [64:0] s;
    s = 65'(a) - 65'(b);
    if (s[64] != s[63]) return s[64] ? S64_MIN : S64_MAX;
    return s[63:0];
  endfunction

  function automatic logic [62:0] sat_add_u63(input logic [62:0] acc,
                                              input logic [Q_W-1:0] v);
    logic [63:0] s;
    s = {1'b0, acc} + 64'(v);
    return s[63] ? {63{1'b1}} : s[62:0];
  endfunction

  function automatic logic [31:0] sat_inc32(input logic [31:0] v);
    return (&v) ? v : v + 32'd1;
  endfunction

  function automatic logic [62:0] floor_sub63(input logic [62:0] a, input logic [62:0] b);
    logic [63:0] d;
    d = {1'b0, a} - {1'b0, b};
    return d[63] ? 63'd0 : d[62:0];
  endfunction

  function automatic logic [31:0] floor_sub32(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] d;
    d = {1'b0, a} - {1'b0, b};
    return d[32] ? 32'd0 : d[31:0];
  endfunction

  state_t              state, state_next;
  logic [2:0]          step;
  logic [BIN_AW-1:0]   clr_ptr;
  logic                clr_done;
  logic [3:0]          cur_stat;
  logic [6:0]          cur_bin;
  logic                cur_stat_ok, cur_bin_ok;
  logic                site_accept;
  logic                in_stat_ok, in_bin_ok;
  logic                load_out;
  prod_ctrl_t          prod_ctrl;
  terms_t              terms;

  stat_rec_t           stat_mem [NUM_STATS];
  bin_rec_t            bin_mem  [DEPTH];
  stat_rec_t           stat_rd, stat_upd, stat_wdata;
  bin_rec_t            bin_rd, bin_upd, bin_wdata;
  logic [STAT_AW-1:0]  stat_addr, stat_waddr;
  logic [BIN_AW-1:0]   bin_addr, bin_waddr;
  logic                stat_we, bin_we;

  logic signed [63:0]  bin_num;
  logic [62:0]         bin_den;
  logic [31:0]         bin_cnt;
  result_t             rd_word;

  // input handshake and index checks
  assign site_stall  = (state != ST_IDLE);
  assign site_accept = site_valid && !site_stall;
  assign in_stat_ok  = (32'(site.stat_index) < NUM_STATS);
  assign in_bin_ok   = (32'(site.bin_index) < NUM_BINS);
  assign clr_done    = (clr_ptr == BIN_AW'(DEPTH - 1));
  assign load_out    = (state == ST_RDOUT) && (!result_valid || !result_stall);

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_done) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (site_accept) begin
          if (site.mode == MODE_READ) begin
            state_next = ST_RDWAIT;
          end else if (!site.missing && in_stat_ok && in_bin_ok) begin
            state_next = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        if (step == STEP_NUM) state_next = ST_CONV;
      end
      ST_CONV:   state_next = ST_UPD;
      ST_UPD:    state_next = ST_IDLE;
      ST_RDWAIT: state_next = ST_RDOUT;
      ST_RDOUT: begin
        if (load_out) state_next = ST_IDLE;
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      step    <= STEP_PAB;
      clr_ptr <= '0;
    end else begin
      state <= state_next;
      if (state == ST_MUL) begin
        step <= step + 3'd1;
      end else begin
        step <= STEP_PAB;
      end
      if (state == ST_CLEAR && !clr_done) clr_ptr <= clr_ptr + BIN_AW'(1);
    end
  end

  // item registers
  always_ff @(posedge clk) begin
    if (site_accept) begin
      cur_stat    <= site.stat_index;
      cur_bin     <= site.bin_index;
      cur_stat_ok <= in_stat_ok;
      cur_bin_ok  <= in_bin_ok;
    end
  end

  // shared product unit
  always_comb begin
    prod_ctrl.load = site_accept;
    prod_ctrl.mul  = (state == ST_MUL);
    prod_ctrl.step = step;
    prod_ctrl.conv = (state == ST_CONV);
  end

  abba_prod_unit u_prod (
    .clk   (clk),
    .site  (site),
    .ctrl  (prod_ctrl),
    .terms (terms)
  );

  // store addressing, entry of a bin is stat * NUM_BINS + bin
  assign stat_addr = STAT_AW'(cur_stat);
  assign bin_addr  = BIN_AW'(32'(cur_stat) * NUM_BINS + 32'(cur_bin));

  // saturating read-modify-write values
  always_comb begin
    stat_upd.numerator   = sat_add_s64(stat_rd.numerator, terms.numerator);
    stat_upd.denominator = sat_add_u63(stat_rd.denominator, terms.denominator);
    stat_upd.abba        = sat_add_u63(stat_rd.abba, terms.abba);
    stat_upd.baba        = sat_add_u63(stat_rd.baba, terms.baba);
    stat_upd.sites       = sat_inc32(stat_rd.sites);
    bin_upd.numerator    = sat_add_s64(bin_rd.numerator, terms.numerator);
    bin_upd.denominator  = sat_add_u63(bin_rd.denominator, terms.denominator);
    bin_upd.sites        = sat_inc32(bin_rd.sites);
  end

  // write port: clearing pass after reset, else the update
  always_comb begin
    if (state == ST_CLEAR) begin
      stat_we    = (32'(clr_ptr) < NUM_STATS);
      stat_waddr = clr_ptr[STAT_AW-1:0];
      stat_wdata = '0;
      bin_we     = 1'b1;
      bin_waddr  = clr_ptr;
      bin_wdata  = '0;
    end else begin
      stat_we    = (state == ST_UPD);
      stat_waddr = stat_addr;
      stat_wdata = stat_upd;
      bin_we     = (state == ST_UPD);
      bin_waddr  = bin_addr;
      bin_wdata  = bin_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (stat_we) stat_mem[stat_waddr] <= stat_wdata;
    stat_rd <= stat_mem[stat_addr];
  end

  always_ff @(posedge clk) begin
    if (bin_we) bin_mem[bin_waddr] <= bin_wdata;
    bin_rd <= bin_mem[bin_addr];
  end

  // readout word, a bin out of range counts as empty
  always_comb begin
    bin_num = cur_bin_ok ? bin_rd.numerator : '0;
    bin_den = cur_bin_ok ? bin_rd.denominator : '0;
    bin_cnt = cur_bin_ok ? bin_rd.sites : '0;
    rd_word = '0;
    if (cur_stat_ok) begin
      rd_word.total_numerator   = stat_rd.numerator;
      rd_word.total_denominator = stat_rd.denominator;
      rd_word.total_abba        = stat_rd.abba;
      rd_word.total_baba        = stat_rd.baba;
      rd_word.total_sites       = stat_rd.sites;
      rd_word.loo_numerator     = sat_sub_s64(stat_rd.numerator, bin_num);
      rd_word.loo_denominator   = floor_sub63(stat_rd.denominator, bin_den);
      rd_word.loo_sites         = floor_sub32(stat_rd.sites, bin_cnt);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load_out) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) result <= rd_word;
  end

endmodule

// ===== rtl/abba_port_checker.sv =====
// abba_port_checker: port-level checks of the accumulator top level over time
// depends on abba_pkg; bound to abba_baba_dstat_accumulator_top below

module abba_port_checker
  import abba_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    site_valid,
  input logic    site_stall,
  input site_t   site,
  input logic    result_valid,
  input logic    result_stall,
  input result_t result
);

  logic site_take;

  assign site_take = site_valid && !site_stall;

  // no result word straight out of reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result word valid after reset");

  // a stalled result word holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result word changed");

  // an accumulate word never makes a result
  a_acc_silent: assert property (@(posedge clk) disable iff (rst)
    site_take && site.mode == MODE_ACC && !result_valid |=> !result_valid)
    else $error("result word after an accumulate word");

  // a readout with a free output register shows its word after the wait and readout states
  a_read_latency: assert property (@(posedge clk) disable iff (rst)
    site_take && site.mode == MODE_READ && !result_valid |-> ##3 result_valid)
    else $error("readout result late");

  // a new result word only follows a readout word
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(site_take && site.mode == MODE_READ, 3))
    else $error("result word without a readout word");

endmodule

bind abba_baba_dstat_accumulator_top abba_port_checker u_port_checker (.*);
